// File: rtl/lrq_pkg.sv
// Shared types and constants of the look-rotation quaternion pipeline.
`timescale 1ns / 1ps
package lrq_pkg;

  // Output format: fraction bits of the quaternion components.
  localparam int FRAC_BITS = 14;
  // Internal fixed-point format: Q30.
  localparam int QI = 30;
  // Width of a signed Q30 value with headroom for sums of matrix entries.
  localparam int Q_W = 34;
  // Width of a raw input component and of an output component.
  localparam int IN_W = 16;
  localparam int OUT_W = 16;
  // Width of a vector component entering the normalizer (cross product needs 33).
  localparam int VEC_W = 33;
  // Width of a component magnitude inside the normalizer.
  localparam int MAG_W = 32;
  // Squared length after normalization lies below 2^62.
  localparam int NRM_W = 62;
  // Even shift steps of the normalizing shifter: 32, 16, 8, 4, 2.
  localparam int NRM_STEPS = 5;
  // Pivot argument width after clamping and its root input width.
  localparam int ARG_W = 34;
  localparam int PIV_IN_W = ARG_W + QI;
  localparam int PIV_R_W = PIV_IN_W / 2;

  typedef logic signed [Q_W-1:0] q30_t;

  // Shepperd branch: positive trace, or largest diagonal element.
  typedef enum logic [1:0] {
    BR_W,
    BR_X,
    BR_Y,
    BR_Z
  } branch_t;

  // Side data of a vector riding along the normalizer root unit.
  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
    logic                  zero;
  } nrm_sb_t;

  // Side data of one normalizer divider lane.
  typedef struct packed {
    logic neg;
    logic zero;
  } dsb_t;

  // Side data of an item riding along the pivot root unit.
  typedef struct packed {
    branch_t br;
    q30_t    d0;
    q30_t    d1;
    q30_t    d2;
    logic    zero;
  } piv_sb_t;

  // Side data of an item riding along the first quaternion divider.
  typedef struct packed {
    branch_t              br;
    logic [PIV_R_W-1:0]   half;
    logic                 hz;
    logic                 zero;
    logic                 neg;
  } qdiv_sb_t;

endpackage

// File: rtl/lrq_isqrt.sv
// Pipelined floor square root, one result bit per stage, with side data.
`timescale 1ns / 1ps
module lrq_isqrt import lrq_pkg::*; #(
  parameter int IN_W = PIV_IN_W,
  parameter int SB_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [IN_W-1:0]   in_val,
  input  logic [SB_W-1:0]   in_sb,
  output logic              out_valid,
  output logic [IN_W/2-1:0] out_root,
  output logic [SB_W-1:0]   out_sb
);

  localparam int R_W = IN_W / 2;
  localparam int REM_W = R_W + 2;

  logic              vld  [R_W];
  logic [IN_W-1:0]   rest [R_W];
  logic [REM_W-1:0]  rem  [R_W];
  logic [R_W-1:0]    root [R_W];
  logic [SB_W-1:0]   sb   [R_W];

  for (genvar k = 0; k < R_W; k++) begin : g_stage
    logic             vld_p;
    logic [IN_W-1:0]  rest_p;
    logic [REM_W-1:0] rem_p;
    logic [R_W-1:0]   root_p;
    logic [SB_W-1:0]  sb_p;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign vld_p  = in_valid;
      assign rest_p = in_val;
      assign rem_p  = '0;
      assign root_p = '0;
      assign sb_p   = in_sb;
    end else begin : g_next
      assign vld_p  = vld[k-1];
      assign rest_p = rest[k-1];
      assign rem_p  = rem[k-1];
      assign root_p = root[k-1];
      assign sb_p   = sb[k-1];
    end

    // Bring down two bits and try the next root bit
    assign rem_sh = {rem_p[REM_W-3:0], rest_p[IN_W-1:IN_W-2]};
    assign trial  = {root_p, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= ge ? rem_sh - trial : rem_sh;
        root[k] <= {root_p[R_W-2:0], ge};
        rest[k] <= rest_p << 2;
        sb[k]   <= sb_p;
      end
    end
  end

  assign out_valid = vld[R_W-1];
  assign out_root  = root[R_W-1];
  assign out_sb    = sb[R_W-1];

endmodule

// File: rtl/lrq_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side data.
`timescale 1ns / 1ps
module lrq_div import lrq_pkg::*; #(
  parameter int NUM_W = 63,
  parameter int DEN_W = 32,
  parameter int Q_BITS = 32,
  parameter int SB_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SB_W-1:0]   in_sb,
  output logic              out_valid,
  output logic [Q_BITS-1:0] out_quot,
  output logic [SB_W-1:0]   out_sb
);

  logic              vld [Q_BITS];
  logic [DEN_W-1:0]  rem [Q_BITS];
  logic [DEN_W-1:0]  den [Q_BITS];
  logic [Q_BITS-1:0] lo  [Q_BITS];
  logic [Q_BITS-1:0] quo [Q_BITS];
  logic [SB_W-1:0]   sb  [Q_BITS];

  for (genvar k = 0; k < Q_BITS; k++) begin : g_stage
    logic              vld_p;
    logic [DEN_W-1:0]  rem_p;
    logic [DEN_W-1:0]  den_p;
    logic [Q_BITS-1:0] lo_p;
    logic [Q_BITS-1:0] quo_p;
    logic [SB_W-1:0]   sb_p;
    logic [DEN_W:0]    sh;
    logic              ge;

    if (k == 0) begin : g_first
      // Upper numerator part is below the divisor when the quotient fits
      assign vld_p = in_valid;
      assign rem_p = DEN_W'(in_num >> Q_BITS);
      assign den_p = in_den;
      assign lo_p  = in_num[Q_BITS-1:0];
      assign quo_p = '0;
      assign sb_p  = in_sb;
    end else begin : g_next
      assign vld_p = vld[k-1];
      assign rem_p = rem[k-1];
      assign den_p = den[k-1];
      assign lo_p  = lo[k-1];
      assign quo_p = quo[k-1];
      assign sb_p  = sb[k-1];
    end

    // Shift in the next numerator bit and subtract when it fits
    assign sh = {rem_p, lo_p[Q_BITS-1]};
    assign ge = sh >= {1'b0, den_p};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? DEN_W'(sh - {1'b0, den_p}) : sh[DEN_W-1:0];
        quo[k] <= {quo_p[Q_BITS-2:0], ge};
        lo[k]  <= lo_p << 1;
        den[k] <= den_p;
        sb[k]  <= sb_p;
      end
    end
  end

  assign out_valid = vld[Q_BITS-1];
  assign out_quot  = quo[Q_BITS-1];
  assign out_sb    = sb[Q_BITS-1];

endmodule

// File: rtl/lrq_unit.sv
// Vector normalizer: squared length, even-shift normalize, root and three divides.
`timescale 1ns / 1ps
module lrq_unit import lrq_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [VEC_W-1:0] v_x,
  input  logic signed [VEC_W-1:0] v_y,
  input  logic signed [VEC_W-1:0] v_z,
  output logic                    out_valid,
  output logic                    zero,
  output q30_t                    o_x,
  output q30_t                    o_y,
  output q30_t                    o_z
);

  localparam int S_W = NRM_W / 2;
  localparam int DNUM_W = MAG_W + QI + 1;

  logic signed [VEC_W-1:0] vin [3];
  assign vin[0] = v_x;
  assign vin[1] = v_y;
  assign vin[2] = v_z;

  // Magnitudes and signs
  logic             v1;
  logic [MAG_W-1:0] a1 [3];
  logic [2:0]       neg1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a1[i]   <= vin[i][VEC_W-1] ? MAG_W'(-vin[i]) : MAG_W'(vin[i]);
        neg1[i] <= vin[i][VEC_W-1];
      end
    end
  end

  // Squares, full and with one low bit dropped
  logic                 v2;
  logic [2*MAG_W-1:0]   sq2  [3];
  logic [2*MAG_W-3:0]   sqh2 [3];
  logic [MAG_W-1:0]     a2   [3];
  logic [2:0]           neg2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq2[i]  <= a1[i] * a1[i];
        sqh2[i] <= a1[i][MAG_W-1:1] * a1[i][MAG_W-1:1];
        a2[i]   <= a1[i];
      end
      neg2 <= neg1;
    end
  end

  // Sum squares; drop a bit from each magnitude when the length is too large
  logic [2*MAG_W-1:0] nsum;
  logic [2*MAG_W-1:0] nhalf;
  logic               big;

  always_comb begin
    nsum  = sq2[0] + sq2[1] + sq2[2];
    nhalf = (2*MAG_W)'(sqh2[0]) + (2*MAG_W)'(sqh2[1]) + (2*MAG_W)'(sqh2[2]);
    big   = |nsum[2*MAG_W-1:NRM_W];
  end

  logic             vv [NRM_STEPS+1];
  logic [NRM_W-1:0] nn [NRM_STEPS+1];
  logic [MAG_W-1:0] aa [NRM_STEPS+1][3];
  logic [2:0]       ng [NRM_STEPS+1];
  logic             zz [NRM_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vv[0] <= 1'b0;
    end else if (en) begin
      vv[0] <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nn[0] <= big ? nhalf[NRM_W-1:0] : nsum[NRM_W-1:0];
      for (int i = 0; i < 3; i++) begin
        aa[0][i] <= big ? {1'b0, a2[i][MAG_W-1:1]} : a2[i];
      end
      ng[0] <= neg2;
      zz[0] <= nsum == '0;
    end
  end

  // Normalize by even shifts until the length reaches [2^60, 2^62)
  for (genvar j = 0; j < NRM_STEPS; j++) begin : g_nrm
    localparam int K = 32 >> j;
    logic lowv;

    assign lowv = nn[j][NRM_W-1 -: K] == '0;

    always_ff @(posedge clk) begin
      if (rst) begin
        vv[j+1] <= 1'b0;
      end else if (en) begin
        vv[j+1] <= vv[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nn[j+1] <= lowv ? nn[j] << K : nn[j];
        for (int i = 0; i < 3; i++) begin
          aa[j+1][i] <= lowv ? aa[j][i] << (K / 2) : aa[j][i];
        end
        ng[j+1] <= ng[j];
        zz[j+1] <= zz[j];
      end
    end
  end

  // Root of the normalized length
  nrm_sb_t        sq_in;
  nrm_sb_t        sq_out;
  logic           sq_v;
  logic [S_W-1:0] sq_root;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_in.mag[i] = aa[NRM_STEPS][i];
    end
    sq_in.neg  = ng[NRM_STEPS];
    sq_in.zero = zz[NRM_STEPS];
  end

  lrq_isqrt #(
    .IN_W (NRM_W),
    .SB_W ($bits(nrm_sb_t))
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vv[NRM_STEPS]),
    .in_val    (nn[NRM_STEPS]),
    .in_sb     (sq_in),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_sb    (sq_out)
  );

  // Form rounded dividends
  logic              pv;
  logic [DNUM_W-1:0] pnum [3];
  logic [S_W-1:0]    pden;
  dsb_t              psb  [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (en) begin
      pv <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pnum[i]     <= {1'b0, sq_out.mag[i], {QI{1'b0}}} + DNUM_W'(sq_root >> 1);
        psb[i].neg  <= sq_out.neg[i];
        psb[i].zero <= sq_out.zero;
      end
      pden <= sq_root;
    end
  end

  // Divide each magnitude by the root
  logic           d_v  [3];
  logic [S_W-1:0] d_q  [3];
  dsb_t           d_sb [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    lrq_div #(
      .NUM_W  (DNUM_W),
      .DEN_W  (S_W),
      .Q_BITS (S_W),
      .SB_W   ($bits(dsb_t))
    ) u_div (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (pv),
      .in_num    (pnum[i]),
      .in_den    (pden),
      .in_sb     (psb[i]),
      .out_valid (d_v[i]),
      .out_quot  (d_q[i]),
      .out_sb    (d_sb[i])
    );
  end

  // Apply signs
  q30_t oq [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_v[0] & d_v[1] & d_v[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        oq[i] <= d_sb[i].neg ? -Q_W'(d_q[i]) : Q_W'(d_q[i]);
      end
      zero <= d_sb[0].zero | d_sb[1].zero | d_sb[2].zero;
    end
  end

  assign o_x = oq[0];
  assign o_y = oq[1];
  assign o_z = oq[2];

endmodule

// File: rtl/look_rotation_quaternion.sv
// Top level: look-rotation basis and Shepperd matrix-to-quaternion pipeline.
//
//   channel | signals                                    | direction
//   --------+--------------------------------------------+----------
//   in      | in_valid, in_ready, fwd_*, up_*            | into block
//   out     | out_valid, out_ready, quat_*, degenerate   | out of block
//
// One item enters per cycle while the pipeline is not frozen; latency is set by the chain of
// one-bit-per-stage root and divide units (normalizer root and divide, pivot
// root, quaternion divide).
// The whole pipeline advances together; it freezes while the output register
// holds an item that is not taken, and in_ready is low only then.
// Reset (rst, synchronous) clears all stage valid bits.
`timescale 1ns / 1ps
module look_rotation_quaternion import lrq_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [IN_W-1:0]  fwd_x,
  input  logic signed [IN_W-1:0]  fwd_y,
  input  logic signed [IN_W-1:0]  fwd_z,
  input  logic signed [IN_W-1:0]  up_x,
  input  logic signed [IN_W-1:0]  up_y,
  input  logic signed [IN_W-1:0]  up_z,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] quat_x,
  output logic signed [OUT_W-1:0] quat_y,
  output logic signed [OUT_W-1:0] quat_z,
  output logic signed [OUT_W-1:0] quat_w,
  output logic                    degenerate
);

  localparam int ARG_X_W = ARG_W + 2;
  localparam logic signed [ARG_X_W-1:0] ONE_ARG = ARG_X_W'(1) <<< QI;
  localparam logic signed [63:0] OUT_LIM = 64'sd1 <<< FRAC_BITS;
  localparam int QNUM_W = ARG_W + QI - 1;

  // Round x / 2^k, half away from zero
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] x, input int k);
    logic [63:0] mag;
    logic [63:0] r;
    mag = x[63] ? 64'(-x) : 64'(x);
    r = (mag + (64'd1 << (k - 1))) >> k;
    return x[63] ? -$signed(r) : $signed(r);
  endfunction

  // Round a Q30 value to the output format and saturate
  function automatic logic signed [OUT_W-1:0] to_out(input q30_t q);
    logic signed [63:0] v;
    v = rnd_shr(64'(q), QI - FRAC_BITS);
    if (v > OUT_LIM) v = OUT_LIM;
    if (v < -OUT_LIM) v = -OUT_LIM;
    return v[OUT_W-1:0];
  endfunction

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Cross product partial products
  logic                     v1;
  logic signed [2*IN_W-1:0] p1 [6];
  logic signed [IN_W-1:0]   f1 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1[0] <= up_y * fwd_z;
      p1[1] <= up_z * fwd_y;
      p1[2] <= up_z * fwd_x;
      p1[3] <= up_x * fwd_z;
      p1[4] <= up_x * fwd_y;
      p1[5] <= up_y * fwd_x;
      f1[0] <= fwd_x;
      f1[1] <= fwd_y;
      f1[2] <= fwd_z;
    end
  end

  // Cross product up x forward
  logic                    v2;
  logic signed [VEC_W-1:0] c2 [3];
  logic signed [VEC_W-1:0] f2 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        c2[i] <= VEC_W'(p1[2*i]) - VEC_W'(p1[2*i+1]);
        f2[i] <= VEC_W'(f1[i]);
      end
    end
  end

  // Normalize forward and right
  logic vf, vc, zf, zc;
  q30_t fq [3];
  q30_t rq [3];

  lrq_unit u_fwd (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v2),
    .v_x       (f2[0]),
    .v_y       (f2[1]),
    .v_z       (f2[2]),
    .out_valid (vf),
    .zero      (zf),
    .o_x       (fq[0]),
    .o_y       (fq[1]),
    .o_z       (fq[2])
  );

  lrq_unit u_right (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v2),
    .v_x       (c2[0]),
    .v_y       (c2[1]),
    .v_z       (c2[2]),
    .out_valid (vc),
    .zero      (zc),
    .o_x       (rq[0]),
    .o_y       (rq[1]),
    .o_z       (rq[2])
  );

  // Products of forward x right
  logic               v3, z3;
  logic signed [63:0] pr3 [6];
  q30_t               f3 [3];
  q30_t               r3 [3];
  logic signed [31:0] fs [3];
  logic signed [31:0] rs [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fs[i] = 32'(fq[i]);
      rs[i] = 32'(rq[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= vf & vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr3[0] <= fs[1] * rs[2];
      pr3[1] <= fs[2] * rs[1];
      pr3[2] <= fs[2] * rs[0];
      pr3[3] <= fs[0] * rs[2];
      pr3[4] <= fs[0] * rs[1];
      pr3[5] <= fs[1] * rs[0];
      f3 <= fq;
      r3 <= rq;
      z3 <= zf | zc;
    end
  end

  // Up' = forward x right, rounded to Q30
  logic v4, z4;
  q30_t u4 [3];
  q30_t f4 [3];
  q30_t r4 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u4[i] <= Q_W'(rnd_shr(pr3[2*i] - pr3[2*i+1], QI));
      end
      f4 <= f3;
      r4 <= r3;
      z4 <= z3;
    end
  end

  // Trace and branch choice
  logic    v5, z5;
  q30_t    t5;
  branch_t br5;
  q30_t    u5 [3];
  q30_t    f5 [3];
  q30_t    r5 [3];
  q30_t    tr;
  branch_t br_next;

  always_comb begin
    tr = r4[0] + u4[1] + f4[2];
    if (tr > 0) begin
      br_next = BR_W;
    end else if (r4[0] > u4[1] && r4[0] > f4[2]) begin
      br_next = BR_X;
    end else if (u4[1] > f4[2]) begin
      br_next = BR_Y;
    end else begin
      br_next = BR_Z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t5  <= tr;
      br5 <= br_next;
      u5  <= u4;
      f5  <= f4;
      r5  <= r4;
      z5  <= z4;
    end
  end

  // Pivot argument and the three numerators of the branch
  logic signed [ARG_X_W-1:0] arg;
  logic [ARG_W-1:0]          argc;
  piv_sb_t                   piv_next;

  always_comb begin
    piv_next.br   = br5;
    piv_next.zero = z5;
    unique case (br5)
      BR_W: begin
        arg         = ARG_X_W'(t5) + ONE_ARG;
        piv_next.d0 = u5[2] - f5[1];
        piv_next.d1 = f5[0] - r5[2];
        piv_next.d2 = r5[1] - u5[0];
      end
      BR_X: begin
        arg         = ONE_ARG + ARG_X_W'(r5[0]) - ARG_X_W'(u5[1]) - ARG_X_W'(f5[2]);
        piv_next.d0 = u5[2] - f5[1];
        piv_next.d1 = u5[0] + r5[1];
        piv_next.d2 = f5[0] + r5[2];
      end
      BR_Y: begin
        arg         = ONE_ARG + ARG_X_W'(u5[1]) - ARG_X_W'(r5[0]) - ARG_X_W'(f5[2]);
        piv_next.d0 = f5[0] - r5[2];
        piv_next.d1 = u5[0] + r5[1];
        piv_next.d2 = f5[1] + u5[2];
      end
      BR_Z: begin
        arg         = ONE_ARG + ARG_X_W'(f5[2]) - ARG_X_W'(r5[0]) - ARG_X_W'(u5[1]);
        piv_next.d0 = r5[1] - u5[0];
        piv_next.d1 = f5[0] + r5[2];
        piv_next.d2 = f5[1] + u5[2];
      end
      default: begin
        arg         = '0;
        piv_next.d0 = '0;
        piv_next.d1 = '0;
        piv_next.d2 = '0;
      end
    endcase
    // Clamp a rounding-negative pivot to zero
    argc = arg[ARG_X_W-1] ? '0 : arg[ARG_W-1:0];
  end

  logic                v6;
  logic [PIV_IN_W-1:0] piv_in6;
  piv_sb_t             piv6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      piv_in6 <= {argc, {QI{1'b0}}};
      piv6    <= piv_next;
    end
  end

  // Pivot root h
  logic               sq_v;
  logic [PIV_R_W-1:0] h;
  piv_sb_t            piv_out;

  lrq_isqrt #(
    .IN_W (PIV_IN_W),
    .SB_W ($bits(piv_sb_t))
  ) u_piv_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v6),
    .in_val    (piv_in6),
    .in_sb     (piv6),
    .out_valid (sq_v),
    .out_root  (h),
    .out_sb    (piv_out)
  );

  // Rounded dividends over 2h and the branch component h/2
  q30_t               dsel [3];
  logic               v7;
  logic [QNUM_W-1:0]  num7 [3];
  logic [PIV_R_W-1:0] den7;
  qdiv_sb_t           qsb7;
  logic [1:0]         neg7;

  assign dsel[0] = piv_out.d0;
  assign dsel[1] = piv_out.d1;
  assign dsel[2] = piv_out.d2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num7[i] <= {(dsel[i] < 0) ? ARG_W'(-dsel[i]) : ARG_W'(dsel[i]), {(QI-1){1'b0}}}
                   + QNUM_W'(h >> 1);
      end
      den7      <= h;
      qsb7.br   <= piv_out.br;
      qsb7.half <= PIV_R_W'(({1'b0, h} + 1'b1) >> 1);
      qsb7.hz   <= h == '0;
      qsb7.zero <= piv_out.zero;
      qsb7.neg  <= dsel[0] < 0;
      neg7[0]   <= dsel[1] < 0;
      neg7[1]   <= dsel[2] < 0;
    end
  end

  // Quaternion dividers
  logic               dv0, dv1, dv2;
  logic [PIV_R_W-1:0] dq0, dq1, dq2;
  qdiv_sb_t           qsb_out;
  logic               neg_b, neg_c;

  lrq_div #(
    .NUM_W  (QNUM_W),
    .DEN_W  (PIV_R_W),
    .Q_BITS (PIV_R_W),
    .SB_W   ($bits(qdiv_sb_t))
  ) u_qdiv0 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v7),
    .in_num    (num7[0]),
    .in_den    (den7),
    .in_sb     (qsb7),
    .out_valid (dv0),
    .out_quot  (dq0),
    .out_sb    (qsb_out)
  );

  lrq_div #(
    .NUM_W  (QNUM_W),
    .DEN_W  (PIV_R_W),
    .Q_BITS (PIV_R_W),
    .SB_W   (1)
  ) u_qdiv1 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v7),
    .in_num    (num7[1]),
    .in_den    (den7),
    .in_sb     (neg7[0]),
    .out_valid (dv1),
    .out_quot  (dq1),
    .out_sb    (neg_b)
  );

  lrq_div #(
    .NUM_W  (QNUM_W),
    .DEN_W  (PIV_R_W),
    .Q_BITS (PIV_R_W),
    .SB_W   (1)
  ) u_qdiv2 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v7),
    .in_num    (num7[2]),
    .in_den    (den7),
    .in_sb     (neg7[1]),
    .out_valid (dv2),
    .out_quot  (dq2),
    .out_sb    (neg_c)
  );

  // Apply signs and place components by branch
  q30_t qa, qb, qc, qh;
  q30_t qx_next, qy_next, qz_next, qw_next;

  always_comb begin
    qa = qsb_out.hz ? '0 : (qsb_out.neg ? -Q_W'(dq0) : Q_W'(dq0));
    qb = qsb_out.hz ? '0 : (neg_b ? -Q_W'(dq1) : Q_W'(dq1));
    qc = qsb_out.hz ? '0 : (neg_c ? -Q_W'(dq2) : Q_W'(dq2));
    qh = Q_W'(qsb_out.half);
    unique case (qsb_out.br)
      BR_W: begin
        qw_next = qh; qx_next = qa; qy_next = qb; qz_next = qc;
      end
      BR_X: begin
        qw_next = qa; qx_next = qh; qy_next = qb; qz_next = qc;
      end
      BR_Y: begin
        qw_next = qa; qx_next = qb; qy_next = qh; qz_next = qc;
      end
      BR_Z: begin
        qw_next = qa; qx_next = qb; qy_next = qc; qz_next = qh;
      end
      default: begin
        qw_next = '0; qx_next = '0; qy_next = '0; qz_next = '0;
      end
    endcase
  end

  logic v8, z8;
  q30_t qx8, qy8, qz8, qw8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8 <= dv0 & dv1 & dv2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qx8 <= qx_next;
      qy8 <= qy_next;
      qz8 <= qz_next;
      qw8 <= qw_next;
      z8  <= qsb_out.zero;
    end
  end

  // Output register: round, saturate, zero a degenerate item
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quat_x     <= z8 ? '0 : to_out(qx8);
      quat_y     <= z8 ? '0 : to_out(qy8);
      quat_z     <= z8 ? '0 : to_out(qz8);
      quat_w     <= z8 ? '0 : to_out(qw8);
      degenerate <= z8;
    end
  end

  localparam logic signed [OUT_W-1:0] Q_LIM = OUT_W'(OUT_LIM);

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> quat_x == '0 && quat_y == '0 && quat_z == '0 && quat_w == '0)
    else $error("degenerate item carries a nonzero quaternion");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> quat_x <= Q_LIM && quat_x >= -Q_LIM && quat_y <= Q_LIM && quat_y >= -Q_LIM
               && quat_z <= Q_LIM && quat_z >= -Q_LIM && quat_w <= Q_LIM && quat_w >= -Q_LIM)
    else $error("quaternion component outside saturation range");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(v8) && $stable(v3) && $stable(qx8))
    else $error("pipeline moved during a stall");

  a_root_nonzero: assert property (@(posedge clk) disable iff (rst)
    sq_v && !piv_out.zero |-> h != '0)
    else $error("pivot root is zero for a valid basis");

endmodule
